// ===== rtl/core/qtbe_pkg.sv =====
// ---------------------------------------------------------------------------
// qtbe_pkg
// Shared types and codes for the quadtree bitmap encoder.
// ---------------------------------------------------------------------------
package qtbe_pkg;

  localparam int unsigned CfgW = 7;

  typedef enum logic [0:0] {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_e;

  typedef enum logic [0:0] {
    REG_ROWS = 1'b0,
    REG_COLS = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    SYM_ZERO = 2'd0,
    SYM_ONE  = 2'd1,
    SYM_DIV  = 2'd2
  } sym_e;

  typedef enum logic [1:0] {
    PH_LOADING  = 2'd0,
    PH_ENCODING = 2'd1,
    PH_DONE     = 2'd2
  } phase_e;

  // Region scan request and result between sequencer and scan unit.
  typedef struct packed {
    logic       start;
    logic [8:0] r0;
    logic [8:0] c0;
    logic [8:0] h;
    logic [8:0] w;
  } scan_req_t;

  typedef struct packed {
    logic done;
    logic any_one;
    logic any_zero;
  } scan_rsp_t;

endpackage

// ===== rtl/core/qtbe_ram.sv =====
// ---------------------------------------------------------------------------
// qtbe_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ---------------------------------------------------------------------------
module qtbe_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 16,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/core/qtbe_scan.sv =====
// ---------------------------------------------------------------------------
// qtbe_scan
// Region scanner: walks a region one pixel per cycle through the pixel RAM
// and reports whether it holds any one and any zero. Stops early once both
// are seen.
// ---------------------------------------------------------------------------
module qtbe_scan
  import qtbe_pkg::*;
#(
  parameter int unsigned MaxRows = 64,
  parameter int unsigned MaxCols = 64,
  localparam int unsigned StoreSize = MaxRows * MaxCols,
  localparam int unsigned AW = (StoreSize > 1) ? $clog2(StoreSize) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  scan_req_t       req_i,
  input  logic [8:0]      ncols_i,
  output logic            ren_o,
  output logic [AW-1:0]   raddr_o,
  input  logic            rdata_i,
  output scan_rsp_t       rsp_o
);

  logic        busy_q, busy_d;
  logic [8:0]  r_q, r_d, c_q, c_d;
  logic        pend_q, pend_d;
  logic        pin_q, pin_d;
  logic        one_q, one_d, zero_q, zero_d;
  logic        lastpix_q, lastpix_d;
  logic [17:0] idx;
  logic        in_range;
  logic        last_pix;
  logic        one_n, zero_n;

  always_comb begin
    idx      = (18'(req_i.r0) + 18'(r_q)) * 18'(ncols_i) + 18'(req_i.c0) + 18'(c_q);
    in_range = idx < 18'(StoreSize);
    last_pix = (r_q == req_i.h - 9'd1) && (c_q == req_i.w - 9'd1);
  end

  assign ren_o   = busy_q;
  assign raddr_o = AW'(idx);

  always_comb begin
    one_n  = one_q  | (pend_q & pin_q & rdata_i);
    zero_n = zero_q | (pend_q & ~(pin_q & rdata_i));
    busy_d = busy_q;
    r_d = r_q;
    c_d = c_q;
    pend_d = 1'b0;
    pin_d = in_range;
    one_d = one_n;
    zero_d = zero_n;
    lastpix_d = lastpix_q;
    rsp_o = '0;
    if (req_i.start) begin
      busy_d = 1'b1;
      r_d = '0;
      c_d = '0;
      one_d = 1'b0;
      zero_d = 1'b0;
      lastpix_d = 1'b0;
    end else if (busy_q) begin
      pend_d = 1'b1;
      lastpix_d = last_pix;
      if (last_pix) begin
        busy_d = 1'b0;
      end else if (c_q == req_i.w - 9'd1) begin
        c_d = '0;
        r_d = r_q + 9'd1;
      end else begin
        c_d = c_q + 9'd1;
      end
    end else if (pend_q) begin
      if (lastpix_q || (one_n && zero_n)) begin
        rsp_o.done = 1'b1;
      end
    end
    if (busy_q && one_n && zero_n && !req_i.start) begin
      busy_d = 1'b0;
      pend_d = 1'b0;
      rsp_o.done = 1'b1;
    end
    rsp_o.any_one  = one_n;
    rsp_o.any_zero = zero_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      pend_q    <= 1'b0;
      lastpix_q <= 1'b0;
      one_q     <= 1'b0;
      zero_q    <= 1'b0;
    end else begin
      busy_q    <= busy_d;
      pend_q    <= pend_d;
      lastpix_q <= lastpix_d;
      one_q     <= one_d;
      zero_q    <= zero_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q   <= r_d;
    c_q   <= c_d;
    pin_q <= pin_d;
  end

endmodule

// ===== rtl/core/quadtree_bitmap_encoder_top.sv =====
// ---------------------------------------------------------------------------
// quadtree_bitmap_encoder_top
// Quadtree encoder of a binary bitmap held in an on-chip pixel RAM.
// ---------------------------------------------------------------------------
// Usage: write rows (index 0) and cols (index 1) on the cfg port while idle.
// Issue a beat with start when busy is low. operation_i = load stores
// pixel_i at the next row-major position. operation_i = step
// pops the next pending region and scans it one pixel per cycle through the
// pixel RAM read port, stopping early when both a one and a zero are seen.
// A step on a region that holds both a one and a zero pushes up to four
// children one per cycle. The symbol beat shows
// on symbol_o/last_o with valid_o high for one cycle; the receiver cannot
// stall. A step once the code is finished gives no beat. Reset returns to
// the loading phase at position 0; pixel RAM contents are not cleared.
// ---------------------------------------------------------------------------
module quadtree_bitmap_encoder_top
  import qtbe_pkg::*;
#(
  parameter int unsigned MAX_ROWS    = 64,
  parameter int unsigned MAX_COLS    = 64,
  parameter int unsigned STACK_DEPTH = 24
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  logic            operation_i,
  input  logic            pixel_i,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [CfgW-1:0] cfg_data_i,
  output logic            valid_o,
  output logic [1:0]      symbol_o,
  output logic            last_o
);

  localparam int unsigned StoreSize = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW  = (StoreSize > 1) ? $clog2(StoreSize) : 1;
  localparam int unsigned SW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned LW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned PW  = $clog2(StoreSize + 1);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_POP   = 6'b000010,
    ST_LOAD  = 6'b000100,
    ST_SCAN  = 6'b001000,
    ST_PUSH  = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_e;

  state_e      state_q, state_d;
  phase_e      phase_q, phase_d;
  logic [6:0]  rows_q, cols_q;
  logic [8:0]  nr, nc;
  logic [PW-1:0] pos_q, pos_d;
  logic [LW-1:0] lvl_q, lvl_d;
  logic [8:0]  g_r0_q, g_c0_q, g_h_q, g_w_q;
  logic [8:0]  g_r0_d, g_c0_d, g_h_d, g_w_d;
  logic [2:0]  kid_q, kid_d;
  logic [2:0]  nkid;
  logic [1:0]  sym_q, sym_d;
  logic        vld_q, vld_d, lst_q, lst_d;
  logic [8:0]  hh, hw;
  logic [35:0] kid_reg;

  logic          st_we;
  logic [SW-1:0] st_waddr, st_raddr;
  logic [35:0]   st_wdata, st_rdata;

  logic          px_we;
  logic [AW-1:0] px_waddr, px_raddr;
  logic          px_ren;
  logic          px_rdata;
  scan_req_t     sreq;
  scan_rsp_t     srsp;

  logic acc;
  assign acc  = start && !busy;
  assign busy = (state_q != ST_IDLE);

  always_comb begin
    nr = (rows_q == 7'd0) ? 9'd1 :
         (32'(rows_q) > MAX_ROWS) ? 9'(MAX_ROWS) : 9'(rows_q);
    nc = (cols_q == 7'd0) ? 9'd1 :
         (32'(cols_q) > MAX_COLS) ? 9'(MAX_COLS) : 9'(cols_q);
    hh = 9'((10'(g_h_q) + 10'd1) >> 1);
    hw = 9'((10'(g_w_q) + 10'd1) >> 1);
    nkid = (g_h_q == 9'd1 || g_w_q == 9'd1) ? 3'd2 : 3'd4;
  end

  // Child kid_q in TL,TR,BL,BR order; pushed in reverse.
  always_comb begin
    kid_reg = {g_r0_q, g_c0_q, g_h_q, g_w_q};
    if (g_h_q == 9'd1) begin
      if (kid_q == 3'd0) kid_reg = {g_r0_q, g_c0_q, 9'd1, hw};
      else kid_reg = {g_r0_q, g_c0_q + hw, 9'd1, g_w_q - hw};
    end else if (g_w_q == 9'd1) begin
      if (kid_q == 3'd0) kid_reg = {g_r0_q, g_c0_q, hh, 9'd1};
      else kid_reg = {g_r0_q + hh, g_c0_q, g_h_q - hh, 9'd1};
    end else begin
      case (kid_q)
        3'd0:    kid_reg = {g_r0_q, g_c0_q, hh, hw};
        3'd1:    kid_reg = {g_r0_q, g_c0_q + hw, hh, g_w_q - hw};
        3'd2:    kid_reg = {g_r0_q + hh, g_c0_q, g_h_q - hh, hw};
        default: kid_reg = {g_r0_q + hh, g_c0_q + hw, g_h_q - hh, g_w_q - hw};
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    pos_d = pos_q;
    lvl_d = lvl_q;
    g_r0_d = g_r0_q; g_c0_d = g_c0_q; g_h_d = g_h_q; g_w_d = g_w_q;
    kid_d = kid_q;
    sym_d = sym_q;
    lst_d = lst_q;
    vld_d = 1'b0;
    st_we = 1'b0;
    st_waddr = SW'(lvl_q);
    st_wdata = kid_reg;
    st_raddr = SW'(lvl_q - LW'(1));
    px_we = 1'b0;
    px_waddr = AW'(pos_q);
    sreq = '0;
    sreq.r0 = g_r0_q; sreq.c0 = g_c0_q; sreq.h = g_h_q; sreq.w = g_w_q;
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          if (operation_i == OP_LOAD) begin
            if (phase_q != PH_LOADING) begin
              phase_d = PH_LOADING;
              pos_d = '0;
              lvl_d = '0;
              px_waddr = '0;
              px_we = 1'b1;
              pos_d = PW'(1);
            end else if (pos_q < PW'(32'(nr) * 32'(nc)) && 32'(pos_q) < StoreSize) begin
              px_we = 1'b1;
              pos_d = pos_q + PW'(1);
            end
          end else if (phase_q == PH_LOADING) begin
            phase_d = PH_ENCODING;
            g_r0_d = '0; g_c0_d = '0; g_h_d = nr; g_w_d = nc;
            lvl_d = '0;
            state_d = ST_LOAD;
          end else if (phase_q == PH_ENCODING) begin
            if (lvl_q == '0) begin
              phase_d = PH_DONE;
            end else begin
              lvl_d = lvl_q - LW'(1);
              state_d = ST_POP;
            end
          end
        end
      end
      ST_POP: begin
        st_raddr = SW'(lvl_q);
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        state_d = ST_SCAN;
        sreq.start = 1'b1;
      end
      ST_SCAN: begin
        if (srsp.done) begin
          kid_d = 3'd0;
          if (!srsp.any_one) begin
            sym_d = SYM_ZERO;
            state_d = ST_EMIT;
          end else if (!srsp.any_zero) begin
            sym_d = SYM_ONE;
            state_d = ST_EMIT;
          end else begin
            sym_d = SYM_DIV;
            kid_d = nkid - 3'd1;
            state_d = ST_PUSH;
          end
        end
      end
      ST_PUSH: begin
        if (32'(lvl_q) < STACK_DEPTH) begin
          if (32'(lvl_q) + 32'(kid_q) < STACK_DEPTH) begin
            st_we = 1'b1;
            lvl_d = lvl_q + LW'(1);
          end
        end
        if (kid_q == 3'd0) state_d = ST_EMIT;
        else kid_d = kid_q - 3'd1;
      end
      ST_EMIT: begin
        vld_d = 1'b1;
        lst_d = (lvl_q == '0);
        if (lvl_q == '0) phase_d = PH_DONE;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Popped entry: registered RAM data is valid in ST_LOAD after ST_POP.
  logic from_pop_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) from_pop_q <= 1'b0;
    else from_pop_q <= (state_q == ST_POP);
  end

  logic [8:0] ld_r0, ld_c0, ld_h, ld_w;
  assign {ld_r0, ld_c0, ld_h, ld_w} = from_pop_q ? st_rdata :
                                     {g_r0_q, g_c0_q, g_h_q, g_w_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_LOADING;
      pos_q   <= '0;
      lvl_q   <= '0;
      rows_q  <= 7'd1;
      cols_q  <= 7'd1;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      pos_q   <= pos_d;
      lvl_q   <= lvl_d;
      vld_q   <= vld_d;
      if (cfg_we_i && cfg_idx_i == REG_ROWS) rows_q <= cfg_data_i;
      if (cfg_we_i && cfg_idx_i == REG_COLS) cols_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (from_pop_q) begin
      {g_r0_q, g_c0_q, g_h_q, g_w_q} <= {ld_r0, ld_c0, ld_h, ld_w};
    end else begin
      {g_r0_q, g_c0_q, g_h_q, g_w_q} <= {g_r0_d, g_c0_d, g_h_d, g_w_d};
    end
    kid_q <= kid_d;
    sym_q <= sym_d;
    lst_q <= lst_d;
  end

  assign valid_o  = vld_q;
  assign symbol_o = sym_q;
  assign last_o   = lst_q;

  qtbe_ram #(.Width(36), .Depth(STACK_DEPTH)) u_stack (
    .clk_i, .we_i(st_we), .waddr_i(st_waddr), .wdata_i(st_wdata),
    .raddr_i(st_raddr), .rdata_o(st_rdata)
  );

  qtbe_ram #(.Width(1), .Depth(StoreSize)) u_pixels (
    .clk_i, .we_i(px_we), .waddr_i(px_waddr), .wdata_i(pixel_i),
    .raddr_i(px_raddr), .rdata_o(px_rdata)
  );

  qtbe_scan #(.MaxRows(MAX_ROWS), .MaxCols(MAX_COLS)) u_scan (
    .clk_i, .rst_ni, .req_i(sreq), .ncols_i(nc), .ren_o(px_ren),
    .raddr_o(px_raddr), .rdata_i(px_rdata), .rsp_o(srsp)
  );

  a_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o) else $error("symbol beat longer than one cycle");
  a_sym: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (symbol_o == SYM_ZERO || symbol_o == SYM_ONE || symbol_o == SYM_DIV))
    else $error("bad symbol");
  a_lvl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(lvl_q) <= STACK_DEPTH) else $error("stack overflow");
  a_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    px_ren |-> state_q == ST_SCAN) else $error("scan outside scan state");

endmodule

// ===== bench/tb_quadtree_bitmap_encoder_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_quadtree_bitmap_encoder_top
// Loads bitmaps of many sizes and patterns, steps out the quadtree code and
// checks every symbol beat against an in-bench encoder model or directed table.
// ---------------------------------------------------------------------------
module tb_quadtree_bitmap_encoder_top;
  import qtbe_pkg::*;

  localparam int MaxDim    = 64;
  localparam int StoreSz   = MaxDim * MaxDim;
  localparam int StackSz   = 24;
  localparam int DogLimit  = 20000;
  localparam int ItemGoal  = 1800;

  typedef struct {
    int r0;
    int c0;
    int h;
    int w;
  } quad_t;

  typedef struct {
    sym_e sym;
    bit   last;
  } code_sym_t;

  typedef enum {K_CFG, K_ITEM} row_kind_e;

  typedef struct {
    row_kind_e kind;
    op_e       op;
    bit        pix;
    reg_idx_e  idx;
    bit [6:0]  data;
    bit        typed;
    sym_e      sym;
    bit        last;
  } dir_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic       operation_i = 1'b0;
  logic       pixel_i = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic       cfg_idx_i = 1'b0;
  logic [6:0] cfg_data_i = '0;
  logic       valid_o;
  logic [1:0] symbol_o;
  logic       last_o;

  quadtree_bitmap_encoder_top DUT (
    .clk_i, .rst_ni, .start, .busy, .operation_i, .pixel_i,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i, .valid_o, .symbol_o, .last_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // encoder model state
  bit       bitmap[StoreSz];
  bit       loaded[StoreSz];
  int       load_pos;
  quad_t    pend[StackSz];
  int       pend_lvl;
  phase_e   enc_phase;
  bit [6:0] cur_rows;
  bit [6:0] cur_cols;

  code_sym_t pending_symbols[$];
  int        errors;
  int        items;
  bit        no_gaps;
  int        pat_mode;
  int        blk_sz;
  bit        blk_val[64];

  function automatic int eff_dim(bit [6:0] v);
    if (v == 0) return 1;
    if (v > MaxDim) return MaxDim;
    return int'(v);
  endfunction

  function automatic void push_quads(quad_t q[4], int n);
    int k;
    k = (n < StackSz - pend_lvl) ? n : StackSz - pend_lvl;
    while (k > 0) begin
      k--;
      pend[pend_lvl] = q[k];
      pend_lvl++;
    end
  endfunction

  function automatic void split_quad(quad_t g);
    quad_t q[4];
    int hh, hw;
    hh = (g.h + 1) / 2;
    hw = (g.w + 1) / 2;
    if (g.h == 1) begin
      q[0] = '{g.r0, g.c0, 1, hw};
      q[1] = '{g.r0, g.c0 + hw, 1, g.w - hw};
      push_quads(q, 2);
    end else if (g.w == 1) begin
      q[0] = '{g.r0, g.c0, hh, 1};
      q[1] = '{g.r0 + hh, g.c0, g.h - hh, 1};
      push_quads(q, 2);
    end else begin
      q[0] = '{g.r0, g.c0, hh, hw};
      q[1] = '{g.r0, g.c0 + hw, hh, g.w - hw};
      q[2] = '{g.r0 + hh, g.c0, g.h - hh, hw};
      q[3] = '{g.r0 + hh, g.c0 + hw, g.h - hh, g.w - hw};
      push_quads(q, 4);
    end
  endfunction

  // True when the next step would only read pixels loaded since reset.
  function automatic bit step_is_safe();
    int nr, nc, idx;
    quad_t g;
    nr = eff_dim(cur_rows);
    nc = eff_dim(cur_cols);
    if (enc_phase == PH_DONE) return 1;
    if (enc_phase == PH_LOADING) g = '{0, 0, nr, nc};
    else if (pend_lvl == 0) return 1;
    else g = pend[pend_lvl - 1];
    for (int r = 0; r < g.h; r++)
      for (int c = 0; c < g.w; c++) begin
        idx = (g.r0 + r) * nc + g.c0 + c;
        if (idx < StoreSz && !loaded[idx]) return 0;
      end
    return 1;
  endfunction

  // Applies one accepted beat; returns 1 and the symbol when one is produced.
  function automatic bit encode_beat(op_e op, bit pix, output code_sym_t res,
                                     output bit counted);
    int nr, nc, ones, idx;
    quad_t g;
    nr = eff_dim(cur_rows);
    nc = eff_dim(cur_cols);
    counted = 1;
    if (op == OP_LOAD) begin
      if (enc_phase != PH_LOADING) begin
        enc_phase = PH_LOADING;
        load_pos = 0;
        pend_lvl = 0;
      end
      if (load_pos < nr * nc) begin
        bitmap[load_pos] = pix;
        loaded[load_pos] = 1;
        load_pos++;
      end else begin
        counted = 0;
      end
      return 0;
    end
    if (enc_phase == PH_DONE) begin
      counted = 0;
      return 0;
    end
    if (enc_phase == PH_LOADING) begin
      pend[0] = '{0, 0, nr, nc};
      pend_lvl = 1;
      enc_phase = PH_ENCODING;
    end
    if (pend_lvl == 0) begin
      enc_phase = PH_DONE;
      return 0;
    end
    pend_lvl--;
    g = pend[pend_lvl];
    ones = 0;
    for (int r = 0; r < g.h; r++)
      for (int c = 0; c < g.w; c++) begin
        idx = (g.r0 + r) * nc + g.c0 + c;
        if (idx < StoreSz) ones += bitmap[idx];
      end
    if (ones == 0) res.sym = SYM_ZERO;
    else if (ones == g.h * g.w) res.sym = SYM_ONE;
    else begin
      res.sym = SYM_DIV;
      split_quad(g);
    end
    res.last = (pend_lvl == 0);
    if (res.last) enc_phase = PH_DONE;
    return 1;
  endfunction

  task automatic pause_after_beat();
    int n;
    if (no_gaps) return;
    n = $urandom_range(0, 9);
    if (n < 6) n = 0;
    else if (n < 9) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 40);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic send_beat(op_e op, bit pix, bit typed = 0,
                           code_sym_t typed_res = '{SYM_ZERO, 1'b0});
    code_sym_t res;
    bit counted;
    if (op == OP_STEP && !step_is_safe()) begin
      op = OP_LOAD;
      typed = 0;
    end
    start <= 1'b1;
    operation_i <= op;
    pixel_i <= pix;
    do @(posedge clk_i); while (busy);
    if (encode_beat(op, pix, res, counted))
      pending_symbols.push_back(typed ? typed_res : res);
    if (counted) items++;
    pause_after_beat();
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_symbols.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, bit [6:0] data);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    if (idx == REG_ROWS) cur_rows = data;
    else cur_cols = data;
    cfg_we_i <= 1'b0;
  endtask

  function automatic bit [6:0] pick_dim(bit big);
    int k;
    if (big) return 7'd64;
    k = $urandom_range(0, 19);
    if (k == 0) return 7'd0;
    if (k == 1) return 7'($urandom_range(65, 127));
    if (k == 2) return 7'($urandom_range(9, 24));
    return 7'($urandom_range(1, 8));
  endfunction

  function automatic bit pattern_pixel(int r, int c);
    case (pat_mode)
      0: return 1'($urandom_range(0, 1));
      1: return blk_val[0];
      2: return blk_val[((r / blk_sz) * 8 + c / blk_sz) % 64];
      default: return $urandom_range(0, 15) == 0;
    endcase
  endfunction

  task automatic run_bitmap(bit big);
    int nr, nc, n;
    bit [6:0] rv, cv;
    rv = pick_dim(big);
    cv = big ? 7'd8 : pick_dim(0);
    if ($urandom_range(0, 1)) begin
      write_reg(REG_ROWS, rv);
      if (big || $urandom_range(0, 5) != 0) write_reg(REG_COLS, cv);
    end else begin
      write_reg(REG_COLS, cv);
      if (big || $urandom_range(0, 5) != 0) write_reg(REG_ROWS, rv);
    end
    nr = eff_dim(cur_rows);
    nc = eff_dim(cur_cols);
    pat_mode = big ? 2 : int'($urandom_range(0, 3));
    blk_sz = 1 << $urandom_range(big ? 3 : 0, 3);
    foreach (blk_val[i]) blk_val[i] = 1'($urandom_range(0, 1));
    no_gaps = ($urandom_range(0, 3) == 0);
    n = nr * nc;
    if (!big && $urandom_range(0, 9) == 0) n = int'($urandom_range(0, n));
    for (int i = 0; i < n; i++) send_beat(OP_LOAD, pattern_pixel(i / nc, i % nc));
    if ($urandom_range(0, 7) == 0)
      repeat ($urandom_range(1, 3)) send_beat(OP_LOAD, 1'($urandom_range(0, 1)));
    while (enc_phase != PH_DONE) begin
      send_beat(OP_STEP, 1'($urandom_range(0, 1)));
      if (!big && enc_phase == PH_ENCODING && $urandom_range(0, 39) == 0) begin
        if ($urandom_range(0, 1))
          write_reg($urandom_range(0, 1) ? REG_ROWS : REG_COLS, pick_dim(0));
        else
          return;
      end
    end
    if ($urandom_range(0, 2) == 0) send_beat(OP_STEP, 1'($urandom_range(0, 1)));
  endtask

  dir_row_t dir_rows[] = '{
    '{K_CFG,  OP_LOAD, 0, REG_ROWS, 7'd1,   0, SYM_ZERO, 0},
    '{K_CFG,  OP_LOAD, 0, REG_COLS, 7'd1,   0, SYM_ZERO, 0},
    '{K_ITEM, OP_LOAD, 1, REG_ROWS, 7'd0,   0, SYM_ZERO, 0},
    '{K_ITEM, OP_STEP, 0, REG_ROWS, 7'd0,   1, SYM_ONE,  1},
    '{K_ITEM, OP_STEP, 1, REG_ROWS, 7'd0,   0, SYM_ZERO, 0},
    '{K_ITEM, OP_LOAD, 0, REG_ROWS, 7'd0,   0, SYM_ZERO, 0},
    '{K_ITEM, OP_STEP, 0, REG_ROWS, 7'd0,   1, SYM_ZERO, 1},
    '{K_CFG,  OP_LOAD, 0, REG_ROWS, 7'd2,   0, SYM_ZERO, 0},
    '{K_CFG,  OP_LOAD, 0, REG_COLS, 7'd2,   0, SYM_ZERO, 0},
    '{K_ITEM, OP_LOAD, 1, REG_ROWS, 7'd0,   0, SYM_ZERO, 0},
    '{K_ITEM, OP_LOAD, 0, REG_ROWS, 7'd0,   0, SYM_ZERO, 0},
    '{K_ITEM, OP_LOAD, 0, REG_ROWS, 7'd0,   0, SYM_ZERO, 0},
    '{K_ITEM, OP_LOAD, 1, REG_ROWS, 7'd0,   0, SYM_ZERO, 0},
    '{K_ITEM, OP_LOAD, 1, REG_ROWS, 7'd0,   0, SYM_ZERO, 0},
    '{K_ITEM, OP_STEP, 0, REG_ROWS, 7'd0,   1, SYM_DIV,  0},
    '{K_ITEM, OP_STEP, 0, REG_ROWS, 7'd0,   1, SYM_ONE,  0},
    '{K_ITEM, OP_STEP, 0, REG_ROWS, 7'd0,   1, SYM_ZERO, 0},
    '{K_ITEM, OP_LOAD, 1, REG_ROWS, 7'd0,   0, SYM_ZERO, 0},
    '{K_ITEM, OP_STEP, 1, REG_ROWS, 7'd0,   0, SYM_ZERO, 0},
    '{K_ITEM, OP_STEP, 0, REG_ROWS, 7'd0,   0, SYM_ZERO, 0},
    '{K_ITEM, OP_STEP, 0, REG_ROWS, 7'd0,   0, SYM_ZERO, 0},
    '{K_ITEM, OP_STEP, 0, REG_ROWS, 7'd0,   0, SYM_ZERO, 0},
    '{K_ITEM, OP_STEP, 0, REG_ROWS, 7'd0,   0, SYM_ZERO, 0},
    '{K_CFG,  OP_LOAD, 0, REG_ROWS, 7'd0,   0, SYM_ZERO, 0},
    '{K_CFG,  OP_LOAD, 0, REG_COLS, 7'd127, 0, SYM_ZERO, 0},
    '{K_CFG,  OP_LOAD, 0, REG_COLS, 7'd0,   0, SYM_ZERO, 0},
    '{K_ITEM, OP_LOAD, 0, REG_ROWS, 7'd0,   0, SYM_ZERO, 0},
    '{K_ITEM, OP_STEP, 1, REG_ROWS, 7'd0,   1, SYM_ZERO, 1}
  };

  // symbol beat checker
  always @(posedge clk_i) begin
    code_sym_t exp_sym;
    if (rst_ni && valid_o) begin
      if (pending_symbols.size() == 0) begin
        $error("unexpected symbol beat: symbol %0d last %0d", symbol_o, last_o);
        errors++;
      end else begin
        exp_sym = pending_symbols.pop_front();
        if (symbol_o !== exp_sym.sym) begin
          $error("symbol: expected %0d, actual %0d", exp_sym.sym, symbol_o);
          errors++;
        end
        if (last_o !== exp_sym.last) begin
          $error("last: expected %0d, actual %0d", exp_sym.last, last_o);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no beat in either direction
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || valid_o || cfg_we_i) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= DogLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    bit big_done;
    errors = 0;
    items = 0;
    no_gaps = 0;
    big_done = 0;
    load_pos = 0;
    pend_lvl = 0;
    enc_phase = PH_LOADING;
    cur_rows = 7'd1;
    cur_cols = 7'd1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == K_CFG) write_reg(dir_rows[i].idx, dir_rows[i].data);
      else send_beat(dir_rows[i].op, dir_rows[i].pix, dir_rows[i].typed,
                     '{dir_rows[i].sym, dir_rows[i].last});
    end

    while (items < ItemGoal) begin
      if (!big_done && items > ItemGoal / 2) begin
        run_bitmap(1);
        big_done = 1;
      end else begin
        run_bitmap(0);
      end
    end

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (errors == 0 && pending_symbols.size() == 0) begin
      $display("Regression PASS");
    end else begin
      if (pending_symbols.size() != 0)
        $error("%0d expected symbols never arrived", pending_symbols.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== quadtree_bitmap_encoder_top.f =====
rtl/core/qtbe_pkg.sv
rtl/core/qtbe_ram.sv
rtl/core/qtbe_scan.sv
rtl/core/quadtree_bitmap_encoder_top.sv
bench/tb_quadtree_bitmap_encoder_top.sv
